/* hw/rtl/time_window_hit_clusterer_top_defines.svh */
// Assertion macros for the time window hit clusterer.
// Used by the port checker; depends on nothing else.
`ifndef TIME_WINDOW_HIT_CLUSTERER_TOP_DEFINES_SVH
`define TIME_WINDOW_HIT_CLUSTERER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TWHC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("twhc: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TWHC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("twhc: next-cycle check failed");

// Next-cycle implication that stays live through reset.
`define TWHC_ASSERT_RST(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("twhc: reset check failed");

`endif

/* hw/rtl/twhc_pkg.sv */
// Shared types for the time window hit clusterer.
// Holds the hit word, activity word and queue word; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package twhc_pkg;

    localparam int TIME_W   = 64;
    localparam int CHAN_W   = 24;
    localparam int CHARGE_W = 32;
    localparam int ADC_W    = 16;
    localparam int DET_W    = 16;

    typedef struct packed {
        logic [TIME_W-1:0]   hit_time;
        logic [CHAN_W-1:0]   hit_channel;
        logic [CHARGE_W-1:0] hit_charge;
        logic [ADC_W-1:0]    hit_peak_adc;
        logic [TIME_W-1:0]   hit_peak_time;
        logic [DET_W-1:0]    hit_detector;
    } t_hit;

    typedef struct packed {
        logic [CHAN_W-1:0]   act_channel_first;
        logic [CHAN_W-1:0]   act_channel_last;
        logic [TIME_W-1:0]   act_time_first;
        logic [TIME_W-1:0]   act_time_last;
        logic [DET_W-1:0]    act_detector;
        logic [CHARGE_W-1:0] act_charge_sum;
        logic [ADC_W-1:0]    act_peak_adc;
        logic [CHAN_W-1:0]   act_peak_channel;
        logic [TIME_W-1:0]   act_peak_time;
    } t_act;

    // Hit tagged by the front end: close means the window ended before this hit.
    typedef struct packed {
        logic close;
        t_hit hit;
    } t_qword;

endpackage

`default_nettype wire

/* hw/rtl/twhc_front.sv */
// Front end: accepts hits, tracks the window start and tags closing hits.
// Depends on twhc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module twhc_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [twhc_pkg::TIME_W-1:0] i_cfg_wdata,
    input  wire logic                        i_hit_valid,
    output logic                             o_hit_stall,
    input  wire twhc_pkg::t_hit              i_hit,
    input  wire logic                        i_q_full,
    output logic                             o_q_push,
    output twhc_pkg::t_qword                 o_q_word
);

    logic [twhc_pkg::TIME_W-1:0] r_window_width;
    logic [twhc_pkg::TIME_W-1:0] r_window_start;
    logic [twhc_pkg::TIME_W-1:0] n_window_start;
    logic [twhc_pkg::TIME_W-1:0] start_eff;
    logic [twhc_pkg::TIME_W-1:0] diff;
    logic                        close;
    logic                        push;

    // An unset (zero) start takes this hit's time.
    always_comb begin
        start_eff      = (r_window_start == '0) ? i_hit.hit_time : r_window_start;
        diff           = i_hit.hit_time - start_eff;
        close          = diff > r_window_width;
        n_window_start = close ? i_hit.hit_time : start_eff;
        push           = i_hit_valid && !i_q_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_width <= '0;
            r_window_start <= '0;
        end else begin
            if (i_cfg_we) begin
                r_window_width <= i_cfg_wdata;
            end
            if (push) begin
                r_window_start <= n_window_start;
            end
        end
    end

    assign o_hit_stall     = i_q_full;
    assign o_q_push        = push;
    assign o_q_word.close  = close;
    assign o_q_word.hit    = i_hit;

endmodule

`default_nettype wire

/* hw/rtl/twhc_queue.sv */
// Short queue of tagged hit words between front and back.
// Depends on twhc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module twhc_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire twhc_pkg::t_qword i_word,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output twhc_pkg::t_qword      o_word
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    twhc_pkg::t_qword   r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               do_push;
    logic               do_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] res;
        res = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
        return res;
    endfunction

    always_comb begin
        do_push = i_push && !o_full;
        do_pop  = i_pop && o_valid;
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_word  = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

/* hw/rtl/twhc_back.sv */
// Back end: folds tagged hits into the open activity and emits closed ones.
// Depends on twhc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module twhc_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire twhc_pkg::t_qword i_word,
    output logic                  o_q_pop,
    input  wire logic             i_q_valid,
    output logic                  o_act_valid,
    input  wire logic             i_act_stall,
    output twhc_pkg::t_act        o_act
);

    logic                          r_open;
    twhc_pkg::t_act                r_acc;
    logic                          r_out_valid;
    twhc_pkg::t_act                r_out;

    logic                          b_open;
    twhc_pkg::t_act                b_acc;
    twhc_pkg::t_act                n_acc;
    logic [twhc_pkg::CHARGE_W:0]   sum_wide;
    logic                          emit;
    logic                          out_free;
    logic                          pop;

    always_comb begin
        emit     = i_word.close && r_open;
        out_free = !r_out_valid || !i_act_stall;
        pop      = i_q_valid && (!emit || out_free);

        // Clear the activity on a close, then fold the hit in.
        b_open = i_word.close ? 1'b0 : r_open;
        b_acc  = i_word.close ? '0 : r_acc;
        n_acc  = b_acc;
        if (!b_open) begin
            n_acc.act_channel_first = i_word.hit.hit_channel;
            n_acc.act_time_first    = i_word.hit.hit_time;
            n_acc.act_detector      = i_word.hit.hit_detector;
        end
        n_acc.act_channel_last = i_word.hit.hit_channel;
        n_acc.act_time_last    = i_word.hit.hit_time;
        sum_wide = {1'b0, b_acc.act_charge_sum} + {1'b0, i_word.hit.hit_charge};
        n_acc.act_charge_sum = sum_wide[twhc_pkg::CHARGE_W] ? '1
                                                            : sum_wide[twhc_pkg::CHARGE_W-1:0];
        if (i_word.hit.hit_peak_adc > b_acc.act_peak_adc) begin
            n_acc.act_peak_adc     = i_word.hit.hit_peak_adc;
            n_acc.act_peak_channel = i_word.hit.hit_channel;
            n_acc.act_peak_time    = i_word.hit.hit_peak_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open      <= 1'b0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_open <= 1'b1;
                r_acc  <= n_acc;
            end
            if (pop && emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_act_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload register, loaded only with the closing record.
    always_ff @(posedge i_clk) begin
        if (pop && emit) begin
            r_out <= r_acc;
        end
    end

    assign o_q_pop      = pop;
    assign o_act_valid  = r_out_valid;
    assign o_act        = r_out;

endmodule

`default_nettype wire

/* hw/rtl/time_window_hit_clusterer_top.sv */
// Path: a closing hit passes through the queue, and its pop loads the activity it closes into the output register.
// Throughput: one hit word per cycle unless the queue is full or a closing word waits on a stalled output.
// Queue of QUEUE_DEPTH words lets front and back stall independently.
// Reset: synchronous, active low; clears window width, window start, queue,
// open activity and output valid. No clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module time_window_hit_clusterer_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // Window width register
    input  wire logic                        i_cfg_we,
    input  wire logic [twhc_pkg::TIME_W-1:0] i_cfg_wdata,
    // Hit channel
    input  wire logic                        i_hit_valid,
    output logic                             o_hit_stall,
    input  wire twhc_pkg::t_hit              i_hit,
    // Activity channel
    output logic                             o_act_valid,
    input  wire logic                        i_act_stall,
    output twhc_pkg::t_act                   o_act
);

    logic             q_push;
    logic             q_pop;
    twhc_pkg::t_qword q_in_word;
    twhc_pkg::t_qword q_out_word;
    logic             q_full;
    logic             q_valid;

    // Front: hold the window start, tag each hit word with its close decision.
    twhc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_hit_valid (i_hit_valid),
        .o_hit_stall (o_hit_stall),
        .i_hit       (i_hit),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_word    (q_in_word)
    );

    // Queue: decouple the accept side from the output stall.
    twhc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_word  (q_in_word),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_word  (q_out_word)
    );

    // Back: fold hits into the activity, advance the record into the output register.
    twhc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_word      (q_out_word),
        .o_q_pop     (q_pop),
        .i_q_valid   (q_valid),
        .o_act_valid (o_act_valid),
        .i_act_stall (i_act_stall),
        .o_act       (o_act)
    );

endmodule

`default_nettype wire

/* hw/rtl/twhc_checker.sv */
// Port checker for the time window hit clusterer, bound to the top level.
// Depends on twhc_pkg and time_window_hit_clusterer_top_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "time_window_hit_clusterer_top_defines.svh"

module twhc_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           o_hit_stall,
    input wire logic           o_act_valid,
    input wire logic           i_act_stall,
    input wire twhc_pkg::t_act o_act
);

    logic act_held;
    logic zero_peak;
    logic peak_clear;

    assign act_held   = o_act_valid && i_act_stall;
    assign zero_peak  = o_act_valid && (o_act.act_peak_adc == '0);
    assign peak_clear = (o_act.act_peak_channel == '0) && (o_act.act_peak_time == '0);

    // A stalled activity word holds.
    `TWHC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, act_held, o_act_valid && $stable(o_act))

    // No peak recorded means no peak channel or time either.
    `TWHC_ASSERT_IMP(a_zero_peak, i_clk, i_rst_n, zero_peak, peak_clear)

    // Reset drops the output word and opens the input side.
    `TWHC_ASSERT_RST(a_rst_out, i_clk, !i_rst_n, !o_act_valid)
    `TWHC_ASSERT_RST(a_rst_in, i_clk, !i_rst_n, !o_hit_stall)

endmodule

bind time_window_hit_clusterer_top twhc_checker u_twhc_checker (.*);

`default_nettype wire
